### rtl/hashed_address_cache_unit_defines.svh
// ----------------------------------------------------------------------------
// hashed address cache unit assertion macros
// shared concurrent assertion forms used by the cache top level
// ----------------------------------------------------------------------------
`ifndef HASHED_ADDRESS_CACHE_UNIT_DEFINES_SVH
`define HASHED_ADDRESS_CACHE_UNIT_DEFINES_SVH

// same-cycle implication
`define HAC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/hac_pkg.sv
// ----------------------------------------------------------------------------
// hac_pkg
// types, codes and constants shared by the hashed address cache modules
// ----------------------------------------------------------------------------
package hac_pkg;

   localparam int TABLE_INDEX_BITS = 10;
   localparam int TABLE_SLOTS      = 1 << TABLE_INDEX_BITS;
   localparam int KEY_BITS         = 64;
   localparam int ENTRY_BITS       = KEY_BITS + 1;
   localparam int ACTION_BITS      = 2;
   localparam int OUTCOME_BITS     = 3;
   localparam int SLOT_FIELD_BITS  = 10;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_BITS        = $clog2(QUEUE_DEPTH);

   localparam logic [KEY_BITS-1:0] HASH_MUL1 = 64'hbf58476d1ce4e5b9;
   localparam logic [KEY_BITS-1:0] HASH_MUL2 = 64'h94d049bb133111eb;
   localparam int HASH_SHIFT1 = 30;
   localparam int HASH_SHIFT2 = 27;
   localparam int HASH_SHIFT3 = 31;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_MAP   = 2'd0,
      ACT_END   = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [OUTCOME_BITS-1:0] {
      OUT_HIT       = 3'd0,
      OUT_INSERTED  = 3'd1,
      OUT_MISS      = 3'd2,
      OUT_FULL      = 3'd3,
      OUT_POP_DUMP  = 3'd4,
      OUT_POP       = 3'd5,
      OUT_NOT_FOUND = 3'd6,
      OUT_CLEARED   = 3'd7
   } outcome_type;

   typedef enum logic {
      MODE_PROBE  = 1'b0,
      MODE_DIRECT = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      KIND_IMMEDIATE = 2'd0,
      KIND_CLEAR     = 2'd1,
      KIND_LOOKUP    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      FRONT_IDLE = 3'd0,
      FRONT_MUL1 = 3'd1,
      FRONT_ADD1 = 3'd2,
      FRONT_MUL2 = 3'd3,
      FRONT_ADD2 = 3'd4,
      FRONT_PUSH = 3'd5
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_CLEAR = 2'd0,
      BACK_IDLE  = 2'd1,
      BACK_ISSUE = 2'd2,
      BACK_CHECK = 2'd3
   } back_state_type;

   typedef struct packed {
      kind_type                    kind;
      logic                        is_end;
      logic [KEY_BITS-1:0]         key;
      logic                        permit;
      logic [TABLE_INDEX_BITS-1:0] slot;
      outcome_type                 imm_outcome;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

### rtl/hashed_address_cache_unit.sv
// ----------------------------------------------------------------------------
// hashed_address_cache_unit
// 64-bit address cache: splitmix64 hashed slots with linear probing or
// direct-mapped overwrite, recorded flags per slot and a whole-table clear
// ----------------------------------------------------------------------------
//  channel   ports                                              direction
//  req       req_valid/ready, action, target_address, permit    in
//  rsp       rsp_valid/ready, outcome, slot_index               out
//  csr       csr_write_enable, csr_write_data (mode)            in
//
//  front: accept, then for lookups hashing through MUL1, ADD1, MUL2 and ADD2 on three shared 32x32
//  multipliers, then a push into the two-entry queue that waits while the queue is full
//  back: each lookup probe passes through ISSUE and CHECK (table ram read is registered);
//  clear writes every slot, one slot a cycle; other codes are answered from the queue head
//  after reset a clearing pass over every slot holds req_ready low
//  the output register lets the front keep working while a response waits
// ----------------------------------------------------------------------------
`include "hashed_address_cache_unit_defines.svh"

module hashed_address_cache_unit import hac_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ACTION_BITS-1:0]     req_action,
   input  logic [KEY_BITS-1:0]        req_target_address,
   input  logic                       req_permit,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [OUTCOME_BITS-1:0]    rsp_outcome,
   output logic [SLOT_FIELD_BITS-1:0] rsp_slot_index,
   input  logic                       csr_write_enable,
   input  logic                       csr_write_data
);

   mode_type        mode_ff, mode_in;
   q_status_type    q_status;
   back_status_type back_status;
   logic            q_push;
   logic            q_pop;
   cmd_type         q_push_cmd;
   cmd_type         q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PROBE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign mode_in = csr_write_enable ? mode_type'(csr_write_data) : mode_ff;

   hac_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_target_address (req_target_address),
      .req_permit         (req_permit),
      .back_status        (back_status),
      .q_status           (q_status),
      .q_push             (q_push),
      .q_push_cmd         (q_push_cmd)
   );

   hac_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .status   (q_status)
   );

   hac_back u_back (
      .clock          (clock),
      .reset          (reset),
      .lookup_mode    (mode_ff),
      .q_status       (q_status),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .status         (back_status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_outcome    (rsp_outcome),
      .rsp_slot_index (rsp_slot_index)
   );

   `HAC_ASSERT_IMPLIES(a_push_not_full, clock, reset, q_push, !q_status.full,
                       "push into full queue")
   `HAC_ASSERT_IMPLIES(a_pop_not_empty, clock, reset, q_pop, !q_status.empty,
                       "pop from empty queue")
   `HAC_ASSERT_IMPLIES(a_no_rsp_in_init, clock, reset, back_status.init_busy, !rsp_valid,
                       "response during init clear")
   `HAC_ASSERT_IMPLIES(a_slot_zero, clock, reset,
                       rsp_valid && (rsp_outcome == OUT_MISS || rsp_outcome == OUT_FULL ||
                       rsp_outcome == OUT_NOT_FOUND || rsp_outcome == OUT_CLEARED),
                       rsp_slot_index == '0, "slot named on slotless outcome")
   `HAC_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready,
                    "front took two transactions back to back")

endmodule

### rtl/hac_ram.sv
// ----------------------------------------------------------------------------
// hac_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module hac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

### rtl/hac_front.sv
// ----------------------------------------------------------------------------
// hac_front
// accepts request transactions, classifies them and hashes lookup keys
// ----------------------------------------------------------------------------
module hac_front import hac_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ACTION_BITS-1:0] req_action,
   input  logic [KEY_BITS-1:0]    req_target_address,
   input  logic                   req_permit,
   input  back_status_type        back_status,
   input  q_status_type           q_status,
   output logic                   q_push,
   output cmd_type                q_push_cmd
);

   front_state_type     state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] x_ff, x_in;
   logic [KEY_BITS-1:0] pll_ff, pll_in;
   logic [31:0]         plh_ff, plh_in;
   logic [31:0]         phl_ff, phl_in;
   logic [KEY_BITS-1:0] mult;
   logic [KEY_BITS-1:0] sum;
   logic [KEY_BITS-1:0] hash;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      x_ff   <= x_in;
      pll_ff <= pll_in;
      plh_ff <= plh_in;
      phl_ff <= phl_in;
   end

   // low 64 bits of x * mult from three 32 by 32 partial products
   assign mult = (state_ff == FRONT_MUL1) ? HASH_MUL1 : HASH_MUL2;
   assign sum  = pll_ff + {plh_ff + phl_ff, 32'b0};
   assign hash = sum ^ (sum >> HASH_SHIFT3);

   assign req_ready  = (state_ff == FRONT_IDLE) && !back_status.init_busy;
   assign q_push     = (state_ff == FRONT_PUSH) && !q_status.full;
   assign q_push_cmd = cmd_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      x_in     = x_ff;
      pll_in   = 64'(x_ff[31:0]) * 64'(mult[31:0]);
      plh_in   = x_ff[31:0] * mult[63:32];
      phl_in   = x_ff[63:32] * mult[31:0];
      case (state_ff)
         FRONT_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in.is_end      = (req_action == ACT_END);
               cmd_in.key         = req_target_address;
               cmd_in.permit      = req_permit;
               cmd_in.slot        = '0;
               cmd_in.kind        = KIND_IMMEDIATE;
               cmd_in.imm_outcome = OUT_MISS;
               x_in = req_target_address ^ (req_target_address >> HASH_SHIFT1);
               state_in = FRONT_PUSH;
               case (req_action)
                  ACT_CLEAR: begin
                     cmd_in.kind = KIND_CLEAR;
                  end
                  ACT_MAP: begin
                     if (req_target_address != '0) begin
                        cmd_in.kind = KIND_LOOKUP;
                        state_in    = FRONT_MUL1;
                     end
                  end
                  ACT_END: begin
                     cmd_in.imm_outcome = OUT_NOT_FOUND;
                     if (req_target_address != '0) begin
                        cmd_in.kind = KIND_LOOKUP;
                        state_in    = FRONT_MUL1;
                     end
                  end
                  default: begin
                     cmd_in.is_end = 1'b0;
                  end
               endcase
            end
         end
         FRONT_MUL1: begin
            state_in = FRONT_ADD1;
         end
         FRONT_ADD1: begin
            x_in     = sum ^ (sum >> HASH_SHIFT2);
            state_in = FRONT_MUL2;
         end
         FRONT_MUL2: begin
            state_in = FRONT_ADD2;
         end
         FRONT_ADD2: begin
            cmd_in.slot = hash[TABLE_INDEX_BITS-1:0];
            state_in    = FRONT_PUSH;
         end
         FRONT_PUSH: begin
            if (!q_status.full) begin
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

endmodule

### rtl/hac_fifo.sv
// ----------------------------------------------------------------------------
// hac_fifo
// short command queue between the classifying front and the table back end
// ----------------------------------------------------------------------------
module hac_fifo import hac_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type status
);

   cmd_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head_cmd     = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### rtl/hac_back.sv
// ----------------------------------------------------------------------------
// hac_back
// carries out queued commands against the slot table and drives responses
// ----------------------------------------------------------------------------
module hac_back import hac_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  mode_type                   lookup_mode,
   input  q_status_type               q_status,
   input  cmd_type                    q_head,
   output logic                       q_pop,
   output back_status_type            status,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [OUTCOME_BITS-1:0]    rsp_outcome,
   output logic [SLOT_FIELD_BITS-1:0] rsp_slot_index
);

   back_state_type                 state_ff, state_in;
   cmd_type                        cmd_ff, cmd_in;
   logic [TABLE_INDEX_BITS-1:0]    addr_ff, addr_in;
   logic [TABLE_INDEX_BITS-1:0]    count_ff, count_in;
   logic                           report_ff, report_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   outcome_type                    outcome_ff, outcome_in;
   logic [SLOT_FIELD_BITS-1:0]     slot_ff, slot_in;

   logic                           ram_we;
   logic [TABLE_INDEX_BITS-1:0]    ram_waddr;
   logic [ENTRY_BITS-1:0]          ram_wdata;
   logic [ENTRY_BITS-1:0]          ram_rdata;

   logic                           out_free;
   logic [KEY_BITS-1:0]            stored_key;
   logic                           stored_flag;
   logic                           match;
   logic                           empty_hit;
   logic [TABLE_INDEX_BITS+SLOT_FIELD_BITS-1:0] addr_ext;
   logic [SLOT_FIELD_BITS-1:0]     addr_field;

   hac_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (addr_ff),
      .read_data     (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_CLEAR;
         addr_ff      <= '0;
         report_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         report_ff    <= report_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      count_ff   <= count_in;
      outcome_ff <= outcome_in;
      slot_ff    <= slot_in;
   end

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign stored_key  = ram_rdata[KEY_BITS-1:0];
   assign stored_flag = ram_rdata[KEY_BITS];
   assign match       = (stored_key == cmd_ff.key);
   assign empty_hit   = (lookup_mode == MODE_DIRECT) ? !match : (stored_key == '0);
   assign addr_ext    = {{SLOT_FIELD_BITS{1'b0}}, addr_ff};
   assign addr_field  = addr_ext[SLOT_FIELD_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      report_in    = report_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      outcome_in   = outcome_ff;
      slot_in      = slot_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      case (state_ff)
         BACK_CLEAR: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == '1) begin
               state_in = BACK_IDLE;
               if (report_ff) begin
                  rsp_valid_in = 1'b1;
                  outcome_in   = OUT_CLEARED;
                  slot_in      = '0;
               end
            end
         end
         BACK_IDLE: begin
            if (!q_status.empty && out_free) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               case (q_head.kind)
                  KIND_CLEAR: begin
                     addr_in   = '0;
                     report_in = 1'b1;
                     state_in  = BACK_CLEAR;
                  end
                  KIND_LOOKUP: begin
                     addr_in  = q_head.slot;
                     count_in = '0;
                     state_in = BACK_ISSUE;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     outcome_in   = q_head.imm_outcome;
                     slot_in      = '0;
                  end
               endcase
            end
         end
         BACK_ISSUE: begin
            state_in = BACK_CHECK;
         end
         BACK_CHECK: begin
            slot_in = '0;
            if (match) begin
               rsp_valid_in = 1'b1;
               slot_in      = addr_field;
               state_in     = BACK_IDLE;
               if (!cmd_ff.is_end) begin
                  outcome_in = OUT_HIT;
               end else if (!stored_flag) begin
                  ram_we     = 1'b1;
                  ram_wdata  = {1'b1, cmd_ff.key};
                  outcome_in = OUT_POP_DUMP;
               end else begin
                  outcome_in = OUT_POP;
               end
            end else if (empty_hit) begin
               rsp_valid_in = 1'b1;
               state_in     = BACK_IDLE;
               if (cmd_ff.is_end) begin
                  outcome_in = OUT_NOT_FOUND;
               end else if (cmd_ff.permit) begin
                  ram_we     = 1'b1;
                  ram_wdata  = {1'b0, cmd_ff.key};
                  outcome_in = OUT_INSERTED;
                  slot_in    = addr_field;
               end else begin
                  outcome_in = OUT_MISS;
               end
            end else if (count_ff == '1) begin
               rsp_valid_in = 1'b1;
               outcome_in   = OUT_FULL;
               state_in     = BACK_IDLE;
            end else begin
               addr_in  = addr_ff + 1'b1;
               count_in = count_ff + 1'b1;
               state_in = BACK_ISSUE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   assign status.init_busy = (state_ff == BACK_CLEAR) && !report_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = outcome_ff;
   assign rsp_slot_index   = slot_ff;

endmodule
